// ===== sv/sus_pkg.sv =====
package sus_pkg;

    // Input beat: one operation on the table.
    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] key;
        logic [7:0]  index;
    } t_in_item;

    // Output beat: the result of one operation.
    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] key_out;
        logic        found;
        logic [7:0]  index_out;
        logic [8:0]  count;
    } t_out_item;

    // Operation kinds.
    localparam logic [2:0] KIND_INSERT   = 3'd0;
    localparam logic [2:0] KIND_APPEND   = 3'd1;
    localparam logic [2:0] KIND_GET      = 3'd2;
    localparam logic [2:0] KIND_INDEX_OF = 3'd3;
    localparam logic [2:0] KIND_MARK     = 3'd4;
    localparam logic [2:0] KIND_SWEEP    = 3'd5;
    localparam logic [2:0] KIND_CLEAR    = 3'd6;

    // Result status codes.
    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_FULL      = 2'd1;
    localparam logic [1:0] STAT_BAD_INDEX = 2'd2;

    // Datapath commands, one per cycle from the controller.
    typedef logic [4:0] t_cmd;
    localparam t_cmd CMD_NONE       = 5'd0;
    localparam t_cmd CMD_LOAD       = 5'd1;
    localparam t_cmd CMD_INS_FIRST  = 5'd2;
    localparam t_cmd CMD_SRCH_INIT  = 5'd3;
    localparam t_cmd CMD_APPEND     = 5'd4;
    localparam t_cmd CMD_SET_FULL   = 5'd5;
    localparam t_cmd CMD_SET_BAD    = 5'd6;
    localparam t_cmd CMD_GET_RD     = 5'd7;
    localparam t_cmd CMD_GET_OUT    = 5'd8;
    localparam t_cmd CMD_SCAN_INIT  = 5'd9;
    localparam t_cmd CMD_SCAN       = 5'd10;
    localparam t_cmd CMD_MARK       = 5'd11;
    localparam t_cmd CMD_SWEEP_INIT = 5'd12;
    localparam t_cmd CMD_SWEEP      = 5'd13;
    localparam t_cmd CMD_SWEEP_END  = 5'd14;
    localparam t_cmd CMD_CLEAR      = 5'd15;
    localparam t_cmd CMD_MID_RD     = 5'd16;
    localparam t_cmd CMD_MID_CMP    = 5'd17;
    localparam t_cmd CMD_LIN_RD     = 5'd18;
    localparam t_cmd CMD_LIN_CMP    = 5'd19;
    localparam t_cmd CMD_SHIFT_INIT = 5'd20;
    localparam t_cmd CMD_SHIFT      = 5'd21;
    localparam t_cmd CMD_PLACE      = 5'd22;
    localparam t_cmd CMD_EMIT       = 5'd23;

    // Status flags from the datapath to the controller.
    typedef struct packed {
        logic [2:0] kind;
        logic       cnt_zero;
        logic       full;
        logic       idx_ge_cnt;
        logic       idx_gt_cnt;
        logic       wide;
        logic       lo_lt_hi;
        logic       key_eq;
        logic       key_lt;
        logic       scan_hit;
        logic       walk_end;
        logic       shift_end;
        logic       out_free;
    } t_dp_stat;

endpackage

// ===== sv/sus_ram.sv =====
module sus_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/sus_ctrl.sv =====
module sus_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  sus_pkg::t_dp_stat i_stat,
    output sus_pkg::t_cmd    o_cmd
);
    import sus_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DECODE = 4'd1;
    localparam logic [3:0] S_SRCH   = 4'd2;
    localparam logic [3:0] S_SCMP   = 4'd3;
    localparam logic [3:0] S_LCMP   = 4'd4;
    localparam logic [3:0] S_PLACE  = 4'd5;
    localparam logic [3:0] S_SHIFT  = 4'd6;
    localparam logic [3:0] S_GET    = 4'd7;
    localparam logic [3:0] S_SCAN   = 4'd8;
    localparam logic [3:0] S_SWEEP  = 4'd9;
    localparam logic [3:0] S_DONE   = 4'd10;

    logic [3:0] r_state;
    logic [3:0] n_state;

    // Next state and the command for this cycle.
    always_comb begin
        n_state = r_state;
        o_cmd   = CMD_NONE;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd   = CMD_LOAD;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_DONE;
                case (i_stat.kind)
                    KIND_INSERT: begin
                        if (i_stat.cnt_zero) begin
                            o_cmd = CMD_INS_FIRST;
                        end else begin
                            o_cmd   = CMD_SRCH_INIT;
                            n_state = S_SRCH;
                        end
                    end
                    KIND_APPEND: begin
                        o_cmd = i_stat.full ? CMD_SET_FULL : CMD_APPEND;
                    end
                    KIND_GET: begin
                        if (i_stat.idx_ge_cnt) begin
                            o_cmd = CMD_SET_BAD;
                        end else begin
                            o_cmd   = CMD_GET_RD;
                            n_state = S_GET;
                        end
                    end
                    KIND_INDEX_OF: begin
                        if (i_stat.idx_gt_cnt) begin
                            o_cmd = CMD_SET_BAD;
                        end else begin
                            o_cmd   = CMD_SCAN_INIT;
                            n_state = S_SCAN;
                        end
                    end
                    KIND_MARK: begin
                        o_cmd = i_stat.idx_ge_cnt ? CMD_SET_BAD : CMD_MARK;
                    end
                    KIND_SWEEP: begin
                        o_cmd   = CMD_SWEEP_INIT;
                        n_state = S_SWEEP;
                    end
                    KIND_CLEAR: begin
                        o_cmd = CMD_CLEAR;
                    end
                    default: begin
                        o_cmd = CMD_NONE;
                    end
                endcase
            end
            // Halving while more than two slots remain, then linear probes.
            S_SRCH: begin
                if (i_stat.wide) begin
                    o_cmd   = CMD_MID_RD;
                    n_state = S_SCMP;
                end else if (i_stat.lo_lt_hi) begin
                    o_cmd   = CMD_LIN_RD;
                    n_state = S_LCMP;
                end else begin
                    n_state = S_PLACE;
                end
            end
            S_SCMP: begin
                o_cmd   = CMD_MID_CMP;
                n_state = i_stat.key_eq ? S_DONE : S_SRCH;
            end
            S_LCMP: begin
                o_cmd = CMD_LIN_CMP;
                if (i_stat.key_eq) begin
                    n_state = S_DONE;
                end else if (i_stat.key_lt) begin
                    n_state = S_PLACE;
                end else begin
                    n_state = S_SRCH;
                end
            end
            // A duplicate was ruled out; now check room before shifting.
            S_PLACE: begin
                if (i_stat.full) begin
                    o_cmd   = CMD_SET_FULL;
                    n_state = S_DONE;
                end else begin
                    o_cmd   = CMD_SHIFT_INIT;
                    n_state = S_SHIFT;
                end
            end
            S_SHIFT: begin
                if (i_stat.shift_end) begin
                    o_cmd   = CMD_PLACE;
                    n_state = S_DONE;
                end else begin
                    o_cmd = CMD_SHIFT;
                end
            end
            S_GET: begin
                o_cmd   = CMD_GET_OUT;
                n_state = S_DONE;
            end
            S_SCAN: begin
                o_cmd = CMD_SCAN;
                if (i_stat.scan_hit || i_stat.walk_end) begin
                    n_state = S_DONE;
                end
            end
            S_SWEEP: begin
                if (i_stat.walk_end) begin
                    o_cmd   = CMD_SWEEP_END;
                    n_state = S_DONE;
                end else begin
                    o_cmd = CMD_SWEEP;
                end
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd   = CMD_EMIT;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_ready = (r_state == S_IDLE);

endmodule

// ===== sv/sus_datapath.sv =====
module sus_datapath #(
    parameter int CAPACITY  = 256,
    parameter int KEY_WIDTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sus_pkg::t_cmd      i_cmd,
    input  sus_pkg::t_in_item  i_item,
    output sus_pkg::t_dp_stat  o_stat,
    output logic               o_valid,
    input  logic               i_ready,
    output sus_pkg::t_out_item o_result
);
    import sus_pkg::*;

    localparam int AW   = $clog2(CAPACITY);
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW > 8) ? CW : 8;

    // Captured operation.
    logic [2:0]           r_kind;
    logic [KEY_WIDTH-1:0] r_key;
    logic [7:0]           r_idx;

    // Table state.
    logic [CW-1:0]        r_count;
    logic [CAPACITY-1:0]  r_marks;

    // Walk state shared by search, shift, scan and sweep.
    logic [CW-1:0]        r_lo;
    logic [CW-1:0]        r_hi;
    logic [CW-1:0]        r_mid;
    logic [CW-1:0]        r_ptr;
    logic [CW-1:0]        r_w;
    logic [AW-1:0]        r_paddr;
    logic                 r_pend;
    logic                 r_pmark;

    // Result being built and the output register.
    logic [1:0]           r_res_status;
    logic [31:0]          r_res_key;
    logic                 r_res_found;
    logic [AW-1:0]        r_res_index;
    logic                 r_out_valid;
    t_out_item            r_out;

    // RAM port signals.
    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [KEY_WIDTH-1:0] ram_wdata;
    logic [AW-1:0]        ram_raddr;
    logic [KEY_WIDTH-1:0] rd_data;

    logic [CW-1:0]        mid_sum;
    logic [CW-1:0]        ptr_dec;
    logic [CMPW-1:0]      idx_ext;
    logic [CMPW-1:0]      cnt_ext;
    logic                 ptr_ge_cnt;
    logic                 key_eq;
    logic                 key_lt;
    logic                 out_free;

    sus_ram #(
        .WIDTH (KEY_WIDTH),
        .DEPTH (CAPACITY)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (rd_data)
    );

    // Compares and derived positions.
    always_comb begin
        mid_sum    = r_lo + ((r_hi - r_lo) >> 1);
        ptr_dec    = r_ptr - CW'(1);
        idx_ext    = CMPW'(r_idx);
        cnt_ext    = CMPW'(r_count);
        ptr_ge_cnt = (r_ptr >= r_count);
        key_eq     = (r_key == rd_data);
        key_lt     = (r_key < rd_data);
        out_free   = !r_out_valid || i_ready;
    end

    // Status to the controller.
    always_comb begin
        o_stat.kind       = r_kind;
        o_stat.cnt_zero   = (r_count == '0);
        o_stat.full       = (r_count == CW'(CAPACITY));
        o_stat.idx_ge_cnt = (idx_ext >= cnt_ext);
        o_stat.idx_gt_cnt = (idx_ext > cnt_ext);
        o_stat.wide       = ((r_hi - r_lo) > CW'(2));
        o_stat.lo_lt_hi   = (r_lo < r_hi);
        o_stat.key_eq     = key_eq;
        o_stat.key_lt     = key_lt;
        o_stat.scan_hit   = r_pend && key_eq;
        o_stat.walk_end   = !r_pend && ptr_ge_cnt;
        o_stat.shift_end  = !r_pend && (r_ptr == r_lo);
        o_stat.out_free   = out_free;
    end

    // Key RAM addressing per command.
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = r_key;
        ram_raddr = '0;
        case (i_cmd)
            CMD_INS_FIRST: begin
                ram_we = 1'b1;
            end
            CMD_APPEND: begin
                ram_we    = 1'b1;
                ram_waddr = r_count[AW-1:0];
            end
            CMD_PLACE: begin
                ram_we    = 1'b1;
                ram_waddr = r_lo[AW-1:0];
            end
            CMD_SHIFT: begin
                ram_we    = r_pend;
                ram_waddr = r_paddr;
                ram_wdata = rd_data;
                ram_raddr = ptr_dec[AW-1:0];
            end
            CMD_SWEEP: begin
                ram_we    = r_pend && r_pmark;
                ram_waddr = r_w[AW-1:0];
                ram_wdata = rd_data;
                ram_raddr = r_ptr[AW-1:0];
            end
            CMD_GET_RD: begin
                ram_raddr = AW'(r_idx);
            end
            CMD_MID_RD: begin
                ram_raddr = mid_sum[AW-1:0];
            end
            CMD_LIN_RD: begin
                ram_raddr = r_lo[AW-1:0];
            end
            CMD_SCAN: begin
                ram_raddr = r_ptr[AW-1:0];
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    // Registers updated by the command of each cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_marks     <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd == CMD_EMIT) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            case (i_cmd)
                CMD_LOAD: begin
                    r_kind       <= i_item.kind;
                    r_key        <= KEY_WIDTH'(i_item.key);
                    r_idx        <= i_item.index;
                    r_res_status <= STAT_OK;
                    r_res_key    <= '0;
                    r_res_found  <= 1'b0;
                    r_res_index  <= '0;
                end
                CMD_INS_FIRST: begin
                    r_count <= CW'(1);
                end
                CMD_SRCH_INIT: begin
                    r_lo <= '0;
                    r_hi <= r_count;
                end
                CMD_APPEND: begin
                    r_res_index <= r_count[AW-1:0];
                    r_count     <= r_count + CW'(1);
                end
                CMD_SET_FULL: begin
                    r_res_status <= STAT_FULL;
                end
                CMD_SET_BAD: begin
                    r_res_status <= STAT_BAD_INDEX;
                end
                CMD_GET_OUT: begin
                    r_res_key <= 32'(rd_data);
                end
                CMD_SCAN_INIT: begin
                    r_ptr  <= CW'(r_idx);
                    r_pend <= 1'b0;
                end
                // Forward scan: one read issued per cycle, data checked next cycle.
                CMD_SCAN: begin
                    if (r_pend && key_eq) begin
                        r_res_found <= 1'b1;
                        r_res_index <= r_paddr;
                        r_pend      <= 1'b0;
                    end else if (!ptr_ge_cnt) begin
                        r_paddr <= r_ptr[AW-1:0];
                        r_pend  <= 1'b1;
                        r_ptr   <= r_ptr + CW'(1);
                    end else begin
                        r_pend <= 1'b0;
                    end
                end
                CMD_MARK: begin
                    r_marks[AW'(r_idx)] <= 1'b1;
                end
                CMD_SWEEP_INIT: begin
                    r_ptr  <= '0;
                    r_w    <= '0;
                    r_pend <= 1'b0;
                end
                // Compaction: the read slot's data and its mark are registered side by side and arrive together.
                CMD_SWEEP: begin
                    if (r_pend && r_pmark) begin
                        r_w <= r_w + CW'(1);
                    end
                    if (!ptr_ge_cnt) begin
                        r_pmark <= r_marks[r_ptr[AW-1:0]];
                        r_pend  <= 1'b1;
                        r_ptr   <= r_ptr + CW'(1);
                    end else begin
                        r_pend <= 1'b0;
                    end
                end
                CMD_SWEEP_END: begin
                    r_count <= r_w;
                    r_marks <= '0;
                end
                CMD_CLEAR: begin
                    r_count <= '0;
                    r_marks <= '0;
                end
                CMD_MID_RD: begin
                    r_mid <= mid_sum;
                end
                CMD_MID_CMP: begin
                    if (key_eq) begin
                        r_res_found <= 1'b1;
                        r_res_index <= r_mid[AW-1:0];
                    end else if (key_lt) begin
                        r_hi <= r_mid;
                    end else begin
                        r_lo <= r_mid + CW'(1);
                    end
                end
                CMD_LIN_CMP: begin
                    if (key_eq) begin
                        r_res_found <= 1'b1;
                        r_res_index <= r_lo[AW-1:0];
                    end else if (!key_lt) begin
                        r_lo <= r_lo + CW'(1);
                    end
                end
                CMD_SHIFT_INIT: begin
                    r_ptr  <= r_count;
                    r_pend <= 1'b0;
                end
                // Shift up from the top: read slot ptr-1, write it to ptr next cycle.
                CMD_SHIFT: begin
                    if (r_ptr != r_lo) begin
                        r_paddr <= r_ptr[AW-1:0];
                        r_pend  <= 1'b1;
                        r_ptr   <= ptr_dec;
                    end else begin
                        r_pend <= 1'b0;
                    end
                end
                CMD_PLACE: begin
                    r_res_index <= r_lo[AW-1:0];
                    r_count     <= r_count + CW'(1);
                end
                CMD_EMIT: begin
                    r_out.status    <= r_res_status;
                    r_out.key_out   <= r_res_key;
                    r_out.found     <= r_res_found;
                    r_out.index_out <= 8'(r_res_index);
                    r_out.count     <= 9'(r_count);
                end
                default: begin
                    r_pend <= r_pend;
                end
            endcase
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

// ===== sv/sorted_unique_set_engine.sv =====
// Channel  | Valid    | Ready    | Payload
// ---------+----------+----------+----------------------------------------
// input    | i_valid  | o_ready  | i_item   (kind, key, index)
// output   | o_valid  | i_ready  | o_result (status, key_out, found,
//          |          |          |           index_out, count)
//
// One operation is worked at a time; a new beat is taken only once the last is done.
// Insert first halves the range, then probes linearly, then shifts entries up one
// by one; index_of and sweep visit the slots one by one. Each walk goes through the
// single read port of the key RAM.
// Reset (synchronous, active low) empties the table and
// clears all marks at once. A result waiting on i_ready holds only the finish step.
module sorted_unique_set_engine #(
    parameter int CAPACITY  = 256,
    parameter int KEY_WIDTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  sus_pkg::t_in_item  i_item,
    output logic               o_valid,
    input  logic               i_ready,
    output sus_pkg::t_out_item o_result
);
    import sus_pkg::*;

    t_cmd     cmd;
    t_dp_stat stat;

    // Sequencer for the operations.
    sus_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    // Key RAM, marks, counters and the output register.
    sus_datapath #(
        .CAPACITY  (CAPACITY),
        .KEY_WIDTH (KEY_WIDTH)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_item   (i_item),
        .o_stat   (stat),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_result (o_result)
    );

endmodule

// ===== sv/sus_checker.sv =====
module sus_checker #(
    parameter int CAPACITY = 256
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_ready,
    input sus_pkg::t_in_item  i_item,
    input logic               o_valid,
    input logic               i_ready,
    input sus_pkg::t_out_item o_result
);
    import sus_pkg::*;

    // A stalled result beat holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_result))
        else $error("output beat changed while stalled");

    // Reset leaves no result pending and the input side open.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && o_ready)
        else $error("block not idle after reset");

    // A full status comes only with the table at capacity and no position.
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_result.status == STAT_FULL) |->
            (o_result.count == 9'(CAPACITY)) && !o_result.found &&
            (o_result.index_out == 8'd0))
        else $error("full status with room left or a position");

    // A bad index reports nothing else.
    a_bad_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_result.status == STAT_BAD_INDEX) |->
            (o_result.key_out == 32'd0) && !o_result.found &&
            (o_result.index_out == 8'd0))
        else $error("bad index status with data fields set");

endmodule

bind sorted_unique_set_engine sus_checker #(
    .CAPACITY (CAPACITY)
) u_sus_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_valid  (i_valid),
    .o_ready  (o_ready),
    .i_item   (i_item),
    .o_valid  (o_valid),
    .i_ready  (i_ready),
    .o_result (o_result)
);
